// File: design/pdsched_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package pdsched_pkg;

	localparam int RESULT_CAP = 16;

	localparam logic [1:0] OP_REGISTER = 2'd0;
	localparam logic [1:0] OP_TICK     = 2'd1;
	localparam logic [1:0] OP_CLEAR    = 2'd2;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_ZERO_PER = 2'd1;
	localparam logic [1:0] ST_FULL     = 2'd2;

	localparam logic KIND_STATUS = 1'b0;
	localparam logic KIND_FIRED  = 1'b1;

	typedef struct packed {
		logic        valid;
		logic        flag;
		logic [7:0]  handle;
		logic [31:0] deadline;
		logic [15:0] period;
	} entry_t;

	typedef struct packed {
		logic ins;
		logic pop;
		logic clr;
		logic mark;
	} cmd_t;

	// a strictly earlier than b, modulo 2^32
	function automatic logic earlier(input logic [31:0] a, input logic [31:0] b);
		logic [31:0] diff;
		diff = a - b;
		return diff[31];
	endfunction

endpackage
`default_nettype wire

// File: design/periodic_deadline_scheduler_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// Channel  Dir  Signals                        Contents
// s_*      in   tvalid tready tdata tuser      task_handle, period / operation
// m_*      out  tvalid tready tdata tuser tlast fired_handle, status / kind / last
//
// Register and clear: the status beat is registered the next cycle after the input beat.
// Tick: advance time, mark due cells, then for each fired task pop the head of the
// cell row and reinsert it, until the head is not due; up to 16 fire per tick.
// Reset empties the table and zeroes the time counter.
// Output stall holds the pop of the next task; input is taken only when idle.
module periodic_deadline_scheduler_unit #(
	parameter int MAX_TASKS = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [23:0] s_tdata,  // task_handle[7:0], period[23:8]
	input  wire logic [1:0]  s_tuser,  // operation[1:0]
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [15:0]      m_tdata,  // fired_handle[7:0], status[9:8], zero pad
	output logic [0:0]       m_tuser,  // kind[0]
	output logic             m_tlast
);

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_MARK = 4'b0010,
		S_POP  = 4'b0100,
		S_INS  = 4'b1000
	} state_t;

	state_t state_q;

	logic [31:0] now_q;
	logic [7:0]  hold_h_q;
	logic [31:0] hold_d_q;
	logic [15:0] hold_p_q;

	logic        out_vq;
	logic        out_kind_q;
	logic [7:0]  out_h_q;
	logic [1:0]  out_st_q;
	logic        out_last_q;

	pdsched_pkg::entry_t cells [MAX_TASKS];
	pdsched_pkg::entry_t nil;
	logic [MAX_TASKS:0]  found;
	logic [MAX_TASKS-1:0] valid_vec;
	pdsched_pkg::cmd_t   cmd;

	logic        beat_in;
	logic [1:0]  op;
	logic [7:0]  in_h;
	logic [15:0] in_p;
	logic        full;
	logic        reg_ok;
	logic        do_pop;
	logic        out_set;
	logic [7:0]  nh;
	logic [31:0] nd;
	logic [15:0] np;

	assign op      = s_tuser;
	assign in_h    = s_tdata[7:0];
	assign in_p    = s_tdata[23:8];
	assign s_tready = (state_q == S_IDLE) && !out_vq;
	assign beat_in  = s_tvalid && s_tready;
	assign full     = cells[MAX_TASKS-1].valid;
	assign reg_ok   = beat_in && op == pdsched_pkg::OP_REGISTER && in_p != 16'd0 && !full;
	assign do_pop   = state_q == S_POP && cells[0].flag && !out_vq;
	assign out_set  = (beat_in && (op == pdsched_pkg::OP_REGISTER ||
		op == pdsched_pkg::OP_CLEAR)) || do_pop;
	assign nil      = '0;

	always_comb begin
		if (state_q == S_INS) begin
			nh = hold_h_q;
			nd = hold_d_q + {16'd0, hold_p_q};
			np = hold_p_q;
		end else begin
			nh = in_h;
			nd = now_q + {16'd0, in_p};
			np = in_p;
		end
	end

	assign cmd.ins  = reg_ok || state_q == S_INS;
	assign cmd.pop  = do_pop;
	assign cmd.clr  = beat_in && op == pdsched_pkg::OP_CLEAR;
	assign cmd.mark = state_q == S_MARK;

	assign found[0] = 1'b0;

	genvar gi;
	generate
		for (gi = 0; gi < MAX_TASKS; gi++) begin : g_cell
			pdsched_cell u_cell (
				.clk          (clk),
				.arst_n       (arst_n),
				.cmd          (cmd),
				.mark_en      (gi < pdsched_pkg::RESULT_CAP),
				.new_handle   (nh),
				.new_deadline (nd),
				.new_period   (np),
				.now          (now_q),
				.left         ((gi == 0) ? nil : cells[(gi == 0) ? 0 : gi - 1]),
				.right        ((gi == MAX_TASKS - 1) ? nil
					: cells[(gi == MAX_TASKS - 1) ? gi : gi + 1]),
				.found_in     (found[gi]),
				.own          (cells[gi]),
				.found_out    (found[gi+1])
			);
			assign valid_vec[gi] = cells[gi].valid;
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			now_q   <= 32'd0;
			out_vq  <= 1'b0;
		end else begin
			if (out_set)
				out_vq <= 1'b1;
			else if (m_tready)
				out_vq <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (beat_in && op == pdsched_pkg::OP_TICK) begin
						now_q   <= now_q + 32'd1;
						state_q <= S_MARK;
					end
				end
				S_MARK: state_q <= S_POP;
				S_POP: begin
					if (!cells[0].flag)
						state_q <= S_IDLE;
					else if (do_pop)
						state_q <= S_INS;
				end
				S_INS: state_q <= S_POP;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (do_pop) begin
			hold_h_q   <= cells[0].handle;
			hold_d_q   <= cells[0].deadline;
			hold_p_q   <= cells[0].period;
			out_kind_q <= pdsched_pkg::KIND_FIRED;
			out_h_q    <= cells[0].handle;
			out_st_q   <= pdsched_pkg::ST_OK;
			out_last_q <= !cells[1].flag;
		end else if (beat_in) begin
			out_kind_q <= pdsched_pkg::KIND_STATUS;
			out_h_q    <= 8'd0;
			out_last_q <= 1'b1;
			if (op == pdsched_pkg::OP_REGISTER && in_p == 16'd0)
				out_st_q <= pdsched_pkg::ST_ZERO_PER;
			else if (op == pdsched_pkg::OP_REGISTER && full)
				out_st_q <= pdsched_pkg::ST_FULL;
			else
				out_st_q <= pdsched_pkg::ST_OK;
		end
	end

	assign m_tvalid = out_vq;
	assign m_tdata  = {6'd0, out_st_q, out_h_q};
	assign m_tuser  = out_kind_q;
	assign m_tlast  = out_last_q;

	a_pop_then_ins: assert property (@(posedge clk) disable iff (!arst_n)
		do_pop |=> state_q == S_INS)
		else $error("pop not followed by reinsert");
	a_ins_room: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_INS |-> !full)
		else $error("reinsert into full table");
	a_clear_empties: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.clr |=> !cells[0].valid)
		else $error("clear left entries");
	a_full_packed: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> valid_vec[0])
		else $error("table not packed");

endmodule
`default_nettype wire

// File: design/pdsched_cell.sv
`timescale 1ns / 1ps
`default_nettype none
module pdsched_cell (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire pdsched_pkg::cmd_t   cmd,
	input  wire logic                mark_en,
	input  wire logic [7:0]          new_handle,
	input  wire logic [31:0]         new_deadline,
	input  wire logic [15:0]         new_period,
	input  wire logic [31:0]         now,
	input  wire pdsched_pkg::entry_t left,
	input  wire pdsched_pkg::entry_t right,
	input  wire logic                found_in,
	output pdsched_pkg::entry_t      own,
	output logic                     found_out
);

	logic        valid_q;
	logic        flag_q;
	logic [7:0]  handle_q;
	logic [31:0] deadline_q;
	logic [15:0] period_q;
	logic        here;

	assign own = '{valid: valid_q, flag: flag_q, handle: handle_q,
		deadline: deadline_q, period: period_q};

	// new entry goes in front of this cell (flagged entries are about to leave)
	assign here = valid_q ? (!flag_q && pdsched_pkg::earlier(new_deadline, deadline_q)) : 1'b1;
	assign found_out = found_in || here;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			flag_q  <= 1'b0;
		end else if (cmd.clr) begin
			valid_q <= 1'b0;
			flag_q  <= 1'b0;
		end else if (cmd.pop) begin
			valid_q <= right.valid;
			flag_q  <= right.flag;
		end else if (cmd.mark) begin
			flag_q <= valid_q && mark_en && !pdsched_pkg::earlier(now, deadline_q);
		end else if (cmd.ins) begin
			if (found_in) begin
				if (left.valid) begin
					valid_q <= 1'b1;
					flag_q  <= left.flag;
				end
			end else if (here) begin
				valid_q <= 1'b1;
				flag_q  <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.pop) begin
			handle_q   <= right.handle;
			deadline_q <= right.deadline;
			period_q   <= right.period;
		end else if (cmd.ins && !cmd.clr) begin
			if (found_in) begin
				if (left.valid) begin
					handle_q   <= left.handle;
					deadline_q <= left.deadline;
					period_q   <= left.period;
				end
			end else if (here) begin
				handle_q   <= new_handle;
				deadline_q <= new_deadline;
				period_q   <= new_period;
			end
		end
	end

endmodule
`default_nettype wire
